// ===== src/lase_pkg.sv =====
// ----------------------------------------------------------------------------
// Local alignment score engine package
// Shared types and constants for the controller and the datapath.
// ----------------------------------------------------------------------------
package lase_pkg;

    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 8;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_MATCH_AWARD    = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_MISMATCH_AWARD = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_GAP_FIRST_COST = 2'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_GAP_MORE_COST  = 2'd3;

    localparam int BASE_BITS     = 8;
    localparam int POS_BITS      = 16;
    localparam int OUT_SCORE_BITS = 16;
    localparam int OUT_QPOS_BITS = 9;
    localparam int OUT_DATA_BITS = 48;

    typedef struct packed {
        logic load_query;
        logic start_row;
        logic calc;
        logic write_cell;
        logic end_row;
    } lase_cmd_t;

    typedef struct packed {
        logic row_done;
        logic is_ref;
        logic out_busy;
    } lase_sts_t;

endpackage

// ===== src/lase_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lase_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/lase_ctrl.sv =====
// ----------------------------------------------------------------------------
// Local alignment controller
// Sequences query loads and the column sweep of one reference row.
// ----------------------------------------------------------------------------
module lase_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  lase_pkg::lase_sts_t sts,
    output lase_pkg::lase_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_CELL
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (sts.is_ref) begin
                        cmd.start_row = 1'b1;
                        state_next    = ST_READ;
                    end else begin
                        cmd.load_query = 1'b1;
                    end
                end
            end
            ST_READ: begin
                if (sts.row_done) begin
                    if (!sts.out_busy) begin
                        cmd.end_row = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end else begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = ST_CELL;
            end
            ST_CELL: begin
                cmd.write_cell = 1'b1;
                state_next     = ST_READ;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/lase_dp.sv =====
// ----------------------------------------------------------------------------
// Local alignment datapath
// Query and row memories, cell arithmetic, best-cell tracking and result.
// ----------------------------------------------------------------------------
module lase_dp #(
    parameter int MAX_QUERY  = 256,
    parameter int SCORE_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [lase_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  logic [lase_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    input  logic                                  in_mode,
    input  logic [lase_pkg::BASE_BITS-1:0]        in_base,
    input  logic                                  in_last,
    input  lase_pkg::lase_cmd_t                   cmd,
    output lase_pkg::lase_sts_t                   sts,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [lase_pkg::OUT_DATA_BITS-1:0]    m_tdata
);

    localparam int AW = $clog2(MAX_QUERY);
    localparam int QW = $clog2(MAX_QUERY + 1);
    localparam int W  = SCORE_BITS + 2;
    localparam logic signed [W-1:0] SMAX = {2'b00, {SCORE_BITS{1'b1}}};
    localparam logic [lase_pkg::POS_BITS-1:0] POS_MAX = '1;

    function automatic logic [SCORE_BITS-1:0] clamp(input logic signed [W-1:0] v);
        logic [SCORE_BITS-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > SMAX) begin
            r = '1;
        end else begin
            r = v[SCORE_BITS-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [W-1:0] max2(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    logic [6:0]              match_reg;
    logic signed [7:0]       mism_reg;
    logic [7:0]              gfirst_reg, gmore_reg;
    logic [QW-1:0]           qlen_reg, vcols_reg, col_reg;
    logic [lase_pkg::BASE_BITS-1:0] base_reg;
    logic                    last_reg;
    logic [lase_pkg::POS_BITS-1:0]  refpos_reg, bref_reg;
    logic [SCORE_BITS-1:0]   bval_reg, diag_reg, left_reg, horiz_reg;
    logic [QW-1:0]           bq_reg;
    logic [SCORE_BITS-1:0]   vert_s_reg, horiz_s_reg, up_s_reg;
    logic signed [W-1:0]     dsum_reg;
    logic                    out_valid_reg;
    logic [lase_pkg::OUT_DATA_BITS-1:0] out_data_reg;

    logic [lase_pkg::BASE_BITS-1:0] q_rd;
    logic [SCORE_BITS-1:0]   s_rd, v_rd, up, vg, h;
    logic signed [W-1:0]     up_x, vg_x, left_x, hz_x, gf_x, gm_x, award_x, diag_x, cell_x;
    logic                    col_valid;

    lase_ram #(.WIDTH(lase_pkg::BASE_BITS), .DEPTH(MAX_QUERY)) u_query_ram (
        .aclk  (aclk),
        .we    (cmd.load_query && (qlen_reg < QW'(MAX_QUERY))),
        .waddr (qlen_reg[AW-1:0]),
        .wdata (in_base),
        .raddr (col_reg[AW-1:0]),
        .rdata (q_rd)
    );

    lase_ram #(.WIDTH(SCORE_BITS), .DEPTH(MAX_QUERY)) u_score_ram (
        .aclk  (aclk),
        .we    (cmd.write_cell),
        .waddr (col_reg[AW-1:0]),
        .wdata (h),
        .raddr (col_reg[AW-1:0]),
        .rdata (s_rd)
    );

    lase_ram #(.WIDTH(SCORE_BITS), .DEPTH(MAX_QUERY)) u_vgap_ram (
        .aclk  (aclk),
        .we    (cmd.write_cell),
        .waddr (col_reg[AW-1:0]),
        .wdata (vert_s_reg),
        .raddr (col_reg[AW-1:0]),
        .rdata (v_rd)
    );

    assign col_valid = col_reg < vcols_reg;
    assign up        = col_valid ? s_rd : '0;
    assign vg        = col_valid ? v_rd : '0;
    assign up_x      = $signed({2'b00, up});
    assign vg_x      = $signed({2'b00, vg});
    assign left_x    = $signed({2'b00, left_reg});
    assign hz_x      = $signed({2'b00, horiz_reg});
    assign diag_x    = $signed({2'b00, diag_reg});
    assign gf_x      = $signed({{(W-8){1'b0}}, gfirst_reg});
    assign gm_x      = $signed({{(W-8){1'b0}}, gmore_reg});
    assign award_x   = (q_rd == base_reg) ? $signed({{(W-7){1'b0}}, match_reg})
                                          : W'(mism_reg);
    assign cell_x    = max2(max2(dsum_reg, $signed({2'b00, vert_s_reg})),
                            $signed({2'b00, horiz_s_reg}));
    assign h         = clamp(cell_x);

    assign sts.row_done = col_reg == qlen_reg;
    assign sts.is_ref   = in_mode;
    assign sts.out_busy = last_reg && out_valid_reg && !m_tready;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = out_data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            vert_s_reg  <= clamp(max2(up_x - gf_x, vg_x - gm_x));
            horiz_s_reg <= clamp(max2(left_x - gf_x, hz_x - gm_x));
            dsum_reg    <= diag_x + award_x;
            up_s_reg    <= up;
        end
        if (cmd.start_row) begin
            base_reg <= in_base;
        end
        if (cmd.end_row && last_reg) begin
            out_data_reg <= {7'd0, lase_pkg::OUT_QPOS_BITS'(bq_reg), bref_reg,
                             lase_pkg::OUT_SCORE_BITS'(bval_reg)};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg     <= 7'd1;
            mism_reg      <= -8'sd1;
            gfirst_reg    <= 8'd1;
            gmore_reg     <= 8'd1;
            qlen_reg      <= '0;
            vcols_reg     <= '0;
            col_reg       <= '0;
            last_reg      <= 1'b0;
            refpos_reg    <= '0;
            bref_reg      <= '0;
            bval_reg      <= '0;
            bq_reg        <= '0;
            diag_reg      <= '0;
            left_reg      <= '0;
            horiz_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    lase_pkg::CFG_MATCH_AWARD:    match_reg  <= cfg_wdata[6:0];
                    lase_pkg::CFG_MISMATCH_AWARD: mism_reg   <= $signed(cfg_wdata);
                    lase_pkg::CFG_GAP_FIRST_COST: gfirst_reg <= cfg_wdata;
                    lase_pkg::CFG_GAP_MORE_COST:  gmore_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.end_row && last_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.load_query && (qlen_reg < QW'(MAX_QUERY))) begin
                qlen_reg <= qlen_reg + 1'b1;
            end
            if (cmd.start_row) begin
                col_reg   <= '0;
                last_reg  <= in_last;
                diag_reg  <= '0;
                left_reg  <= '0;
                horiz_reg <= '0;
                if (refpos_reg != POS_MAX) begin
                    refpos_reg <= refpos_reg + 1'b1;
                end
            end
            if (cmd.write_cell) begin
                diag_reg  <= up_s_reg;
                left_reg  <= h;
                horiz_reg <= horiz_s_reg;
                col_reg   <= col_reg + 1'b1;
                if (bref_reg == '0 || h > bval_reg) begin
                    bval_reg <= h;
                    bref_reg <= refpos_reg;
                    bq_reg   <= col_reg + 1'b1;
                end
            end
            if (cmd.end_row) begin
                if (last_reg) begin
                    vcols_reg     <= '0;
                    refpos_reg    <= '0;
                    bref_reg      <= '0;
                    bval_reg      <= '0;
                    bq_reg        <= '0;
                end else begin
                    vcols_reg <= qlen_reg;
                end
            end
        end
    end

endmodule

// ===== src/local_alignment_score_engine.sv =====
// ----------------------------------------------------------------------------
// Local alignment score engine
// Smith-Waterman local alignment with affine gaps of a stored query against
// a streamed reference, reporting the best score and its end position.
// ----------------------------------------------------------------------------
// Query bases (tuser low) are appended to the query memory while the input
// stays ready for the next one. A reference base (tuser high) fills one row
// of cells by sweeping the query columns through the shared cell unit; each
// column passes a read, a calculate and a write step, and no new transfer is
// accepted until the row is done. The read step covers the registered reads
// of the cell memories. A reference base with tlast set produces one result
// transfer and restarts the reference side; if the previous result is still
// waiting on m_tready, the end of that row is held until it leaves.
module local_alignment_score_engine #(
    parameter int MAX_QUERY  = 256,
    parameter int SCORE_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // base[7:0]
    input  logic        s_tuser,   // mode[0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // best_score[15:0], best_ref_pos[31:16],
                                   // best_query_pos[40:32], zeros above
);

    lase_pkg::lase_cmd_t cmd;
    lase_pkg::lase_sts_t sts;

    lase_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lase_dp #(.MAX_QUERY(MAX_QUERY), .SCORE_BITS(SCORE_BITS)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_mode   (s_tuser),
        .in_base   (s_tdata),
        .in_last   (s_tlast),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== src/lase_checker.sv =====
// ----------------------------------------------------------------------------
// Local alignment port checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module lase_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Result transfer changed while stalled.");

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[47:41] == 7'd0)
        else $error("Result padding bits are not zero.");

    a_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[40:32] != 9'd0 |-> m_tdata[31:16] != 16'd0)
        else $error("Query position reported without a reference position.");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[31:16] == 16'd0 |-> m_tdata[15:0] == 16'd0)
        else $error("Score reported without any cell.");

endmodule

bind local_alignment_score_engine lase_checker u_lase_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
